### design/ssr_pkg.sv
`timescale 1ns / 1ps
package ssr_pkg;

  // Register bytes hold at most eight pattern or replacement bytes.
  localparam int REG_BYTES = 8;
  localparam int LEN_W     = 4;
  localparam int DATA_W    = 64;
  localparam int CFG_IDX_W = 2;

  // Longest run of results that one input byte can cause.
  localparam int RUN_MAX = 8;
  localparam int IDX_W   = $clog2(RUN_MAX);

  // Jobs waiting between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH     = 2'd0,
    REG_PATTERN_BYTES      = 2'd1,
    REG_REPLACEMENT_LENGTH = 2'd2,
    REG_REPLACEMENT_BYTES  = 2'd3
  } ssr_reg_t;

  // One job: the bytes that one input causes, and whether it closes the text.
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [LEN_W-1:0]        count;
    logic                    end_flag;
  } ssr_job_t;

  typedef struct packed {
    logic     valid;
    ssr_job_t job;
  } ssr_push_t;

  typedef struct packed {
    logic     valid;
    ssr_job_t job;
  } ssr_head_t;

endpackage

### design/ssr_in_if.sv
`timescale 1ns / 1ps
interface ssr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink (input valid, input in_byte, input end_of_stream, output ready);
endinterface

### design/ssr_out_if.sv
`timescale 1ns / 1ps
interface ssr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       stream_done;
  logic       last_of_run;

  modport source (output valid, output out_byte, output byte_valid, output stream_done,
                  output last_of_run, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input stream_done,
                input last_of_run, output ready);
endinterface

### design/ssr_cfg_if.sv
`timescale 1ns / 1ps
interface ssr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ssr_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [ssr_pkg::DATA_W-1:0]      wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

### design/ssr_front.sv
`timescale 1ns / 1ps
module ssr_front #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  ssr_cfg_if.sink             cfg,
  ssr_in_if.sink              in,
  input  logic                queue_full,
  output ssr_pkg::ssr_push_t  push
);

  localparam int WIN   = (MAX_PATTERN < ssr_pkg::REG_BYTES) ? MAX_PATTERN
                                                            : ssr_pkg::REG_BYTES;
  localparam int RCAP  = (MAX_REPLACEMENT < ssr_pkg::REG_BYTES) ? MAX_REPLACEMENT
                                                                : ssr_pkg::REG_BYTES;
  localparam int CNT_W = $clog2(WIN + 1);

  logic [ssr_pkg::LEN_W-1:0]  pat_len_r, rep_len_r;
  logic [ssr_pkg::DATA_W-1:0] pat_bytes_r, rep_bytes_r;
  logic [WIN-1:0][7:0]        win_r, win_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;

  logic [WIN-1:0][7:0]        win_app;
  logic [CNT_W-1:0]           cnt_app;
  logic [ssr_pkg::LEN_W-1:0]  plen, rlen;
  logic                       full_win, hit, in_fire, cfg_fire;
  ssr_pkg::ssr_job_t          job;

  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid;
  assign in.ready  = !queue_full;
  assign in_fire   = in.valid && !queue_full;

  assign plen = (pat_len_r > ssr_pkg::LEN_W'(WIN)) ? ssr_pkg::LEN_W'(WIN) : pat_len_r;
  assign rlen = (rep_len_r > ssr_pkg::LEN_W'(RCAP)) ? ssr_pkg::LEN_W'(RCAP) : rep_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r   <= '0;
      pat_bytes_r <= '0;
      rep_len_r   <= '0;
      rep_bytes_r <= '0;
    end else if (cfg_fire) begin
      unique case (ssr_pkg::ssr_reg_t'(cfg.reg_index))
        ssr_pkg::REG_PATTERN_LENGTH:     pat_len_r   <= cfg.wdata[ssr_pkg::LEN_W-1:0];
        ssr_pkg::REG_PATTERN_BYTES:      pat_bytes_r <= cfg.wdata;
        ssr_pkg::REG_REPLACEMENT_LENGTH: rep_len_r   <= cfg.wdata[ssr_pkg::LEN_W-1:0];
        ssr_pkg::REG_REPLACEMENT_BYTES:  rep_bytes_r <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // Window with the new byte appended, and the match check once it is full.
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      win_app[i] = (CNT_W'(i) == cnt_r) ? in.in_byte : win_r[i];
    end
    cnt_app  = cnt_r + CNT_W'(1);
    full_win = (ssr_pkg::LEN_W'(cnt_app) == plen);
    hit      = 1'b1;
    for (int i = 0; i < WIN; i++) begin
      if (ssr_pkg::LEN_W'(i) < plen && win_app[i] != pat_bytes_r[8*i +: 8]) begin
        hit = 1'b0;
      end
    end
  end

  always_comb begin
    job          = '0;
    job.end_flag = in.end_of_stream;
    win_nxt      = win_r;
    cnt_nxt      = cnt_r;
    if (plen == '0) begin
      job.bytes[0] = in.in_byte;
      job.count    = ssr_pkg::LEN_W'(1);
    end else if (full_win && hit) begin
      job.bytes = rep_bytes_r;
      job.count = rlen;
      cnt_nxt   = '0;
    end else if (in.end_of_stream) begin
      // A miss at end of stream, or a short window, flushes every pending byte.
      for (int i = 0; i < WIN; i++) begin
        job.bytes[i] = win_app[i];
      end
      job.count = ssr_pkg::LEN_W'(cnt_app);
      cnt_nxt   = '0;
    end else if (full_win) begin
      job.bytes[0] = win_app[0];
      job.count    = ssr_pkg::LEN_W'(1);
      for (int i = 0; i < WIN - 1; i++) begin
        win_nxt[i] = win_app[i + 1];
      end
      win_nxt[WIN-1] = 8'h00;
      cnt_nxt        = CNT_W'(plen - ssr_pkg::LEN_W'(1));
    end else begin
      win_nxt = win_app;
      cnt_nxt = cnt_app;
    end
  end

  assign push.valid = in_fire && (job.count != '0 || job.end_flag);
  assign push.job   = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cfg_fire &&
                 (ssr_pkg::ssr_reg_t'(cfg.reg_index) == ssr_pkg::REG_PATTERN_LENGTH ||
                  ssr_pkg::ssr_reg_t'(cfg.reg_index) == ssr_pkg::REG_PATTERN_BYTES)) begin
      cnt_r <= '0;
    end else if (in_fire) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      win_r <= win_nxt;
    end
  end

endmodule

### design/ssr_queue.sv
`timescale 1ns / 1ps
module ssr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  ssr_pkg::ssr_push_t  push,
  output logic                full,
  input  logic                pop,
  output ssr_pkg::ssr_head_t  head
);

  ssr_pkg::ssr_job_t                  mem_r [ssr_pkg::QUEUE_DEPTH];
  logic [ssr_pkg::PTR_W-1:0]          wr_ptr_r, rd_ptr_r;
  logic [ssr_pkg::QCNT_W-1:0]         cnt_r;
  logic                               do_push;

  assign full       = (cnt_r == ssr_pkg::QCNT_W'(ssr_pkg::QUEUE_DEPTH));
  assign do_push    = push.valid && !full;
  assign head.valid = (cnt_r != '0);
  assign head.job   = mem_r[rd_ptr_r];

  function automatic logic [ssr_pkg::PTR_W-1:0] ptr_inc(input logic [ssr_pkg::PTR_W-1:0] p);
    ptr_inc = (p == ssr_pkg::PTR_W'(ssr_pkg::QUEUE_DEPTH - 1)) ? '0 : p + ssr_pkg::PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      cnt_r <= cnt_r + ssr_pkg::QCNT_W'(do_push) - ssr_pkg::QCNT_W'(pop);
    end
  end

endmodule

### design/ssr_back.sv
`timescale 1ns / 1ps
module ssr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ssr_pkg::ssr_head_t  head,
  output logic                pop,
  ssr_out_if.source           out
);

  logic [ssr_pkg::IDX_W-1:0] idx_r;
  logic                      out_valid_r;
  logic [7:0]                byte_r;
  logic                      byte_valid_r, done_r, last_r;
  logic                      load, is_last, bare;

  assign bare    = (head.job.count == '0);
  assign is_last = bare ||
                   ({1'b0, idx_r} + ssr_pkg::LEN_W'(1) == head.job.count);
  assign load    = head.valid && (!out_valid_r || out.ready);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r <= is_last ? '0 : idx_r + ssr_pkg::IDX_W'(1);
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r       <= bare ? 8'h00 : head.job.bytes[idx_r];
      byte_valid_r <= !bare;
      last_r       <= is_last;
      done_r       <= is_last && head.job.end_flag;
    end
  end

  assign out.valid       = out_valid_r;
  assign out.out_byte    = byte_r;
  assign out.byte_valid  = byte_valid_r;
  assign out.stream_done = done_r;
  assign out.last_of_run = last_r;

  // A run that has started keeps its job at the queue head until it is done.
  a_run_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != '0 |-> head.valid)
    else $error("run index advanced without a job at the queue head");

  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    head.valid && !bare |-> {1'b0, idx_r} < head.job.count)
    else $error("run index beyond the job byte count");

  a_pop_moves_index_home: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> idx_r == '0)
    else $error("run index not cleared after the job left the queue");

  a_done_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    load && head.job.end_flag && is_last |=> out_valid_r && done_r && last_r)
    else $error("end of text not marked on the last result of its run");

endmodule

### design/stream_search_replace.sv
`timescale 1ns / 1ps
// Path: a byte accepted on in_ch is written as a job into the queue, and its first result is
// then loaded into the registered output stage that drives out_ch.
// Throughput: one input transaction per cycle while each causes at most one result and out_ch
// is ready; the output sequencer sends one result per cycle while out_ch is ready.
// Reset (rst_n low at a clock edge): registers, window and queue are emptied, output invalid.
module stream_search_replace #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  ssr_cfg_if.sink   cfg_ch,
  ssr_in_if.sink    in_ch,
  ssr_out_if.source out_ch
);

  // The front holds the configuration registers and the window of pending bytes. For each
  // input transaction it decides at once whether the window matched, missed or is flushed,
  // and packs every byte that transaction causes into one job.
  ssr_pkg::ssr_push_t push;
  ssr_pkg::ssr_head_t head;
  logic               queue_full;
  logic               pop;

  ssr_front #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_ch),
    .in         (in_ch),
    .queue_full (queue_full),
    .push       (push)
  );

  // The short job queue lets the front keep taking bytes while the back is still sending a
  // multi-byte replacement or a flush, and lets the back drain while the source idles.
  ssr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (queue_full),
    .pop   (pop),
    .head  (head)
  );

  // The back walks each job one byte per cycle, while the sink is ready, into a registered
  // output stage; the sink's ready feeds the queue's pop directly, but not the input ready.
  ssr_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .head  (head),
    .pop   (pop),
    .out   (out_ch)
  );

endmodule
